// ===== rtl/snc_pkg.sv =====
// ----------------------------------------------------------------------------
// snc_pkg: shared types, constants and functions
// Word widths and the fixed shift-add scaling steps of the time conversion.
// ----------------------------------------------------------------------------
package snc_pkg;

  localparam int WordW     = 32;
  localparam int DivStages = WordW;   // one quotient bit per stage
  localparam int NsShift   = 10;
  localparam int NsYW      = WordW - 1 - NsShift;  // n >> 10 of a positive n

  typedef logic [WordW-1:0] word_t;

  // x * 1000 modulo 2^32: x*1024 + x*8 - x*32
  function automatic word_t times_thousand(input word_t x);
    times_thousand = (x << 10) + (x << 3) - (x << 5);
  endfunction

  // Approximate n / 1000 for a non-negative n: y + (3y >> 7) + (9y >> 14)
  function automatic word_t approx_div_thousand(input word_t n);
    logic [NsYW-1:0] y;
    logic [NsYW+1:0] y3;
    logic [NsYW+3:0] y9;
    y  = n[WordW-2:NsShift];
    y3 = {2'b00, y} + {1'b0, y, 1'b0};
    y9 = {4'b0000, y} + {1'b0, y, 3'b000};
    approx_div_thousand = word_t'(y) + word_t'(y3 >> 7) + word_t'(y9 >> 14);
  endfunction

endpackage

// ===== rtl/sec_nsec_to_clock_cycles.sv =====
// ----------------------------------------------------------------------------
// sec_nsec_to_clock_cycles
// Converts a seconds/nanoseconds time value into clock cycles of a
// configured period: microsecond scaling, then a pipelined unsigned divide.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | start, busy          | seconds, nanoseconds
//  config   | cfg_valid, cfg_ready | cfg_data (clock_period)
//  result   | done                 | clock_cycles
//
// An item enters every cycle; busy stays low. Each result passes the two
// scaling stages, the 32-stage restoring divider (one quotient bit per
// stage) and the output register. done is high for one cycle per result;
// the receiver cannot hold results off. Synchronous reset clears the valid
// bits and sets the clock period to 1.
module sec_nsec_to_clock_cycles
  import snc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic signed [31:0] seconds,
  input  logic signed [31:0] nanoseconds,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  output logic              done,
  output logic [31:0]       clock_cycles
);

  word_t clock_period;

  // scaling stages
  logic  s1_vld, s1_neg;
  word_t s1_sec_k, s1_usec_ns;
  logic  s2_vld, s2_neg;
  word_t s2_total;

  // divider stages: output of stage j
  logic              d_vld [DivStages];
  logic              d_neg [DivStages];
  word_t             d_rem [DivStages];
  word_t             d_quo [DivStages];

  logic [WordW:0]    trial [DivStages];
  logic              fits  [DivStages];
  word_t             rem_in [DivStages];
  word_t             quo_in [DivStages];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_period <= word_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      clock_period <= cfg_data;
    end
  end

  // stage 1: sign check, first times-thousand, nanoseconds to microseconds
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
    s1_neg     <= seconds[31] | nanoseconds[31];
    s1_sec_k   <= times_thousand(word_t'(seconds));
    s1_usec_ns <= approx_div_thousand(word_t'(nanoseconds));
  end

  // stage 2: second times-thousand and the 32-bit microsecond sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_neg   <= s1_neg;
    s2_total <= times_thousand(s1_sec_k) + s1_usec_ns;
  end

  // restoring divide; a zero period gives all-ones naturally
  always_comb begin
    for (int j = 0; j < DivStages; j++) begin
      rem_in[j] = (j == 0) ? '0       : d_rem[(j == 0) ? 0 : j-1];
      quo_in[j] = (j == 0) ? s2_total : d_quo[(j == 0) ? 0 : j-1];
      trial[j]  = {rem_in[j], quo_in[j][WordW-1]};
      fits[j]   = trial[j] >= {1'b0, clock_period};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DivStages; j++) begin
        d_vld[j] <= 1'b0;
      end
    end else begin
      d_vld[0] <= s2_vld;
      for (int j = 1; j < DivStages; j++) begin
        d_vld[j] <= d_vld[j-1];
      end
    end
    d_neg[0] <= s2_neg;
    for (int j = 1; j < DivStages; j++) begin
      d_neg[j] <= d_neg[j-1];
    end
    for (int j = 0; j < DivStages; j++) begin
      d_rem[j] <= fits[j] ? word_t'(trial[j] - {1'b0, clock_period})
                          : word_t'(trial[j]);
      d_quo[j] <= {quo_in[j][WordW-2:0], fits[j]};
    end
  end

  // output register: negative input gives 0, zero quotient gives the period
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_vld[DivStages-1];
    end
    if (d_neg[DivStages-1]) begin
      clock_cycles <= '0;
    end else if (d_quo[DivStages-1] == '0) begin
      clock_cycles <= clock_period;
    end else begin
      clock_cycles <= d_quo[DivStages-1];
    end
  end

endmodule
